/* hw/rtl/pcpd_pkg.sv */
package pcpd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH         = 4;

    localparam int BYTE_W   = 8;
    localparam int RGB_W    = 24;
    localparam int ROW_W    = 15;
    localparam int CROW_W   = 18;
    localparam int OFFS_W   = 16;
    localparam int HEIGHT_W = 15;
    localparam int CFG_W    = 16;

    localparam logic [BYTE_W-1:0] BYTE_END = 8'hFF;

    localparam logic [0:0] ACT_LOAD = 1'b0;
    localparam logic [0:0] ACT_DATA = 1'b1;

    localparam logic [0:0] CFG_Y_OFFSET   = 1'b0;
    localparam logic [0:0] CFG_TEX_HEIGHT = 1'b1;

    localparam logic [HEIGHT_W-1:0] TEX_HEIGHT_RST = 15'd128;

    typedef enum logic [2:0] {
        PH_TOP  = 3'd0,
        PH_LEN  = 3'd1,
        PH_PAD1 = 3'd2,
        PH_DATA = 3'd3,
        PH_PAD2 = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_DONE  = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic              idx_ok;
        logic [BYTE_W-1:0] idx;
        logic [RGB_W-1:0]  rgb;
        logic [ROW_W-1:0]  row;
    } t_op;

endpackage

/* hw/rtl/pcpd_in_if.sv */
interface pcpd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  byte_value;
    logic [23:0] load_rgb;

    modport source (output valid, output action, output byte_value, output load_rgb,
                     input ready);
    modport sink   (input valid, input action, input byte_value, input load_rgb,
                     output ready);
endinterface

/* hw/rtl/pcpd_out_if.sv */
interface pcpd_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        column_done;

    modport source (output valid, output row, output red, output green, output blue,
                     output column_done, input ready);
    modport sink   (input valid, input row, input red, input green, input blue,
                     input column_done, output ready);
endinterface

/* hw/rtl/patch_column_post_decoder.sv */
// channel  dir  transfer moves
// i_item   in   action, byte_value, load_rgb (palette load or column byte)
// o_pix    out  row, red, green, blue, column_done (pixel or column end)
// i_cfg_*  in   write: 0 = patch_y_offset, 1 = texture_height
//
// One item per cycle sustained while the queue is not full. A pixel or done
// result passes through the queue slot, palette read register and output register.
// Synchronous active-low reset; palette contents stay undefined until loaded.
// The 4-entry queue lets input keep flowing while o_pix is stalled; i_item
// stalls only once the queue and both back stages are full.
module patch_column_post_decoder #(
    parameter int PALETTE_ENTRIES = pcpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pcpd_in_if.sink                        i_item,
    pcpd_out_if.source                     o_pix,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [pcpd_pkg::CFG_W-1:0]     i_cfg_data
);

    logic signed [pcpd_pkg::OFFS_W-1:0]   r_y_offset;
    logic        [pcpd_pkg::HEIGHT_W-1:0] r_tex_height;

    logic          full, empty, push, pop;
    pcpd_pkg::t_op push_op, pop_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_offset   <= '0;
            r_tex_height <= pcpd_pkg::TEX_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcpd_pkg::CFG_Y_OFFSET:   r_y_offset   <= i_cfg_data;
                pcpd_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data[pcpd_pkg::HEIGHT_W-1:0];
                default:                  r_y_offset   <= r_y_offset;
            endcase
        end
    end

    pcpd_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_y_offset   (r_y_offset),
        .i_tex_height (r_tex_height),
        .i_full       (full),
        .o_push       (push),
        .o_op         (push_op)
    );

    pcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_op    (pop_op),
        .o_empty (empty)
    );

    pcpd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (pop_op),
        .i_empty (empty),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule

/* hw/rtl/pcpd_ram.sv */
module pcpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pcpd_front.sv */
module pcpd_front #(
    parameter int PALETTE_ENTRIES = pcpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pcpd_in_if.sink                           i_item,
    input  logic signed [pcpd_pkg::OFFS_W-1:0]   i_y_offset,
    input  logic        [pcpd_pkg::HEIGHT_W-1:0] i_tex_height,
    input  logic                              i_full,
    output logic                              o_push,
    output pcpd_pkg::t_op                     o_op
);

    localparam logic [pcpd_pkg::BYTE_W:0] NUM_ENTRIES = (pcpd_pkg::BYTE_W+1)'(PALETTE_ENTRIES);

    pcpd_pkg::t_phase                     r_phase, n_phase;
    logic [pcpd_pkg::BYTE_W-1:0]          r_top, n_top;
    logic [pcpd_pkg::BYTE_W-1:0]          r_left, n_left;
    logic signed [pcpd_pkg::CROW_W-1:0]   r_row, n_row;

    logic                                 accept;
    logic                                 in_range;
    logic [pcpd_pkg::BYTE_W-1:0]          left_dec;

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;
    assign left_dec     = r_left - 8'd1;
    assign in_range     = !r_row[pcpd_pkg::CROW_W-1] &&
                          (r_row[pcpd_pkg::CROW_W-2:0] <
                           (pcpd_pkg::CROW_W-1)'(i_tex_height));

    always_comb begin
        n_phase = r_phase;
        n_top   = r_top;
        n_left  = r_left;
        n_row   = r_row;
        if (accept && i_item.action == pcpd_pkg::ACT_DATA) begin
            unique case (r_phase)
                pcpd_pkg::PH_TOP: begin
                    if (i_item.byte_value != pcpd_pkg::BYTE_END) begin
                        n_top   = i_item.byte_value;
                        n_phase = pcpd_pkg::PH_LEN;
                    end
                end
                pcpd_pkg::PH_LEN: begin
                    n_left  = i_item.byte_value;
                    n_row   = pcpd_pkg::CROW_W'(i_y_offset) +
                              $signed({{(pcpd_pkg::CROW_W-pcpd_pkg::BYTE_W){1'b0}}, r_top});
                    n_phase = pcpd_pkg::PH_PAD1;
                end
                pcpd_pkg::PH_PAD1: begin
                    n_phase = (r_left != '0) ? pcpd_pkg::PH_DATA : pcpd_pkg::PH_PAD2;
                end
                pcpd_pkg::PH_DATA: begin
                    n_row  = r_row + 18'sd1;
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = pcpd_pkg::PH_PAD2;
                    end
                end
                default: begin
                    n_phase = pcpd_pkg::PH_TOP;
                end
            endcase
        end
    end

    always_comb begin
        o_push      = 1'b0;
        o_op.kind   = pcpd_pkg::OP_LOAD;
        o_op.idx    = i_item.byte_value;
        o_op.idx_ok = ({1'b0, i_item.byte_value} < NUM_ENTRIES);
        o_op.rgb    = i_item.load_rgb;
        o_op.row    = r_row[pcpd_pkg::ROW_W-1:0];
        if (accept) begin
            if (i_item.action == pcpd_pkg::ACT_LOAD) begin
                o_push = 1'b1;
            end else begin
                unique case (r_phase)
                    pcpd_pkg::PH_TOP: begin
                        o_op.kind = pcpd_pkg::OP_DONE;
                        o_push    = (i_item.byte_value == pcpd_pkg::BYTE_END);
                    end
                    pcpd_pkg::PH_DATA: begin
                        o_op.kind = pcpd_pkg::OP_PIXEL;
                        o_push    = in_range;
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcpd_pkg::PH_TOP;
            r_top   <= '0;
            r_left  <= '0;
            r_row   <= '0;
        end else begin
            r_phase <= n_phase;
            r_top   <= n_top;
            r_left  <= n_left;
            r_row   <= n_row;
        end
    end

endmodule

/* hw/rtl/pcpd_queue.sv */
module pcpd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcpd_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output pcpd_pkg::t_op o_op,
    output logic          o_empty
);

    localparam int PW = $clog2(pcpd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(pcpd_pkg::QUEUE_DEPTH + 1);

    pcpd_pkg::t_op   r_slot [pcpd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(pcpd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/pcpd_back.sv */
module pcpd_back #(
    parameter int PALETTE_ENTRIES = pcpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pcpd_pkg::t_op i_op,
    input  logic          i_empty,
    output logic          o_pop,
    pcpd_out_if.source    o_pix
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic                          r_s1_valid;
    logic                          r_s1_done;
    logic                          r_s1_hit;
    logic [pcpd_pkg::ROW_W-1:0]    r_s1_row;

    logic                          r_out_valid;
    logic                          r_out_done;
    logic [pcpd_pkg::ROW_W-1:0]    r_out_row;
    logic [pcpd_pkg::RGB_W-1:0]    r_out_rgb;

    logic                          out_free, s1_adv, s1_free;
    logic                          is_load, ram_we, ram_re;
    logic [pcpd_pkg::RGB_W-1:0]    rdata;

    assign out_free = !r_out_valid || o_pix.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign o_pop    = !i_empty && s1_free;
    assign is_load  = (i_op.kind == pcpd_pkg::OP_LOAD);
    assign ram_we   = o_pop && is_load && i_op.idx_ok;
    assign ram_re   = o_pop && (i_op.kind == pcpd_pkg::OP_PIXEL);

    pcpd_ram #(
        .WIDTH (pcpd_pkg::RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_op.idx[AW-1:0]),
        .i_wdata (i_op.rgb),
        .i_re    (ram_re),
        .i_raddr (i_op.idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_done <= (i_op.kind == pcpd_pkg::OP_DONE);
            r_s1_hit  <= i_op.idx_ok;
            r_s1_row  <= i_op.row;
        end
        if (s1_adv) begin
            r_out_done <= r_s1_done;
            r_out_row  <= r_s1_done ? '0 : r_s1_row;
            r_out_rgb  <= (r_s1_done || !r_s1_hit) ? '0 : rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop && !is_load;
            end
            if (out_free) begin
                r_out_valid <= s1_adv;
            end
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.row         = r_out_row;
    assign o_pix.red         = r_out_rgb[23:16];
    assign o_pix.green       = r_out_rgb[15:8];
    assign o_pix.blue        = r_out_rgb[7:0];
    assign o_pix.column_done = r_out_done;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT       = 400000;
    localparam int DRAIN_TAIL  = 8;
    localparam int PHASE_ITEMS = 105;
    localparam int N_PHASES    = 10;

    typedef struct packed {
        logic                        action;
        logic [pcpd_pkg::BYTE_W-1:0] value;
        logic [pcpd_pkg::RGB_W-1:0]  rgb;
    } t_item;

    typedef struct packed {
        logic [pcpd_pkg::ROW_W-1:0] row;
        logic [7:0]                 red;
        logic [7:0]                 green;
        logic [7:0]                 blue;
        logic                       done;
    } t_pixel;

    typedef struct {
        t_item  it;
        bit     typed;
        bit     has_res;
        t_pixel res;
    } t_tab_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [0:0]                 cfg_idx;
    logic [pcpd_pkg::CFG_W-1:0] cfg_data;

    pcpd_in_if  item_if();
    pcpd_out_if pix_if();

    patch_column_post_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_pix      (pix_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the decoder
    logic [pcpd_pkg::RGB_W-1:0]    pal_mem [256];
    bit                            pal_set [256];
    logic [pcpd_pkg::BYTE_W-1:0]   pal_set_idx [$];
    pcpd_pkg::t_phase              ph;
    logic [pcpd_pkg::BYTE_W-1:0]   top_q;
    logic [pcpd_pkg::BYTE_W-1:0]   left_q;
    logic [pcpd_pkg::CROW_W-1:0]   crow;
    logic [pcpd_pkg::OFFS_W-1:0]   y_off;
    logic [pcpd_pkg::HEIGHT_W-1:0] tex_h;

    t_pixel pending_pix [$];
    int     errs   = 0;
    int     cycles = 0;
    bit     calm   = 1'b0;
    int     stall_left = 0;

    function automatic bit decode_item(input t_item it, output t_pixel px);
        bit hit;
        hit = 1'b0;
        px  = '0;
        if (it.action == pcpd_pkg::ACT_LOAD) begin
            pal_mem[it.value] = it.rgb;
            if (!pal_set[it.value]) begin
                pal_set[it.value] = 1'b1;
                pal_set_idx.push_back(it.value);
            end
            return 1'b0;
        end
        case (ph)
            pcpd_pkg::PH_TOP: begin
                if (it.value == pcpd_pkg::BYTE_END) begin
                    px.done = 1'b1;
                    hit     = 1'b1;
                end else begin
                    top_q = it.value;
                    ph    = pcpd_pkg::PH_LEN;
                end
            end
            pcpd_pkg::PH_LEN: begin
                left_q = it.value;
                crow   = {{(pcpd_pkg::CROW_W-pcpd_pkg::OFFS_W){y_off[pcpd_pkg::OFFS_W-1]}},
                          y_off} + pcpd_pkg::CROW_W'(top_q);
                ph     = pcpd_pkg::PH_PAD1;
            end
            pcpd_pkg::PH_PAD1: begin
                ph = (left_q != 0) ? pcpd_pkg::PH_DATA : pcpd_pkg::PH_PAD2;
            end
            pcpd_pkg::PH_DATA: begin
                if (!crow[pcpd_pkg::CROW_W-1] && crow < pcpd_pkg::CROW_W'(tex_h)) begin
                    px.row = crow[pcpd_pkg::ROW_W-1:0];
                    {px.red, px.green, px.blue} = pal_mem[it.value];
                    hit = 1'b1;
                end
                crow   = crow + pcpd_pkg::CROW_W'(1);
                left_q = left_q - 8'd1;
                if (left_q == 0) ph = pcpd_pkg::PH_PAD2;
            end
            default: begin
                ph = pcpd_pkg::PH_TOP;
            end
        endcase
        return hit;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly well-formed posts with random content, loads mixed in
    function automatic t_item random_item();
        t_item it;
        int    r;
        it.action = pcpd_pkg::ACT_DATA;
        it.value  = 8'($urandom);
        it.rgb    = 24'($urandom);
        r = $urandom_range(0, 99);
        if (r < 12) begin
            it.action = pcpd_pkg::ACT_LOAD;
            return it;
        end
        case (ph)
            pcpd_pkg::PH_TOP: begin
                if (r < 17) it.value = pcpd_pkg::BYTE_END;
                else if (r < 75) it.value = 8'($urandom_range(0, 40));
                else it.value = 8'($urandom_range(0, 254));
            end
            pcpd_pkg::PH_LEN: begin
                if (r < 22) it.value = 8'd0;
                else if (r < 85) it.value = 8'($urandom_range(1, 24));
            end
            pcpd_pkg::PH_DATA: begin
                it.value = pal_set_idx[$urandom_range(0, pal_set_idx.size() - 1)];
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_tab_row tab_load(input logic [7:0] idx, input logic [23:0] rgb);
        t_tab_row t;
        t.it      = '{pcpd_pkg::ACT_LOAD, idx, rgb};
        t.typed   = 1'b1;
        t.has_res = 1'b0;
        t.res     = '0;
        return t;
    endfunction

    function automatic t_tab_row tab_byte(input logic [7:0] b);
        t_tab_row t;
        t.it      = '{pcpd_pkg::ACT_DATA, b, 24'h0};
        t.typed   = 1'b0;
        t.has_res = 1'b0;
        t.res     = '0;
        return t;
    endfunction

    function automatic t_tab_row tab_pix(input logic [7:0] b, input logic [14:0] row,
                                         input logic [23:0] rgb);
        t_tab_row t;
        t.it      = '{pcpd_pkg::ACT_DATA, b, 24'h0};
        t.typed   = 1'b1;
        t.has_res = 1'b1;
        t.res     = '{row, rgb[23:16], rgb[15:8], rgb[7:0], 1'b0};
        return t;
    endfunction

    function automatic t_tab_row tab_drop(input logic [7:0] b);
        t_tab_row t;
        t = tab_byte(b);
        t.typed = 1'b1;
        return t;
    endfunction

    function automatic t_tab_row tab_end();
        t_tab_row t;
        t.it      = '{pcpd_pkg::ACT_DATA, pcpd_pkg::BYTE_END, 24'h0};
        t.typed   = 1'b1;
        t.has_res = 1'b1;
        t.res     = '{15'd0, 8'd0, 8'd0, 8'd0, 1'b1};
        return t;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    task automatic send_item(input t_item it, output bit hit, output t_pixel px);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.action     <= it.action;
        item_if.byte_value <= it.value;
        item_if.load_rgb   <= it.rgb;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        hit = decode_item(it, px);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [pcpd_pkg::OFFS_W-1:0] off,
                              input logic [pcpd_pkg::HEIGHT_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= pcpd_pkg::CFG_Y_OFFSET;
        cfg_data <= off;
        @(posedge i_clk);
        cfg_idx  <= pcpd_pkg::CFG_TEX_HEIGHT;
        cfg_data <= {1'($urandom_range(0, 1)), h};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        y_off = off;
        tex_h = h;
    endtask

    // result side: random stalls, none in calm stretches
    initial begin
        pix_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pix_if.ready <= 1'b0;
            end else if (calm) begin
                pix_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                pix_if.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pending_pix.size() == 0) begin
                $error("o_pix: transfer with no result pending");
                errs++;
            end else begin
                want = pending_pix.pop_front();
                check_field("row", 32'(want.row), 32'(pix_if.row));
                check_field("red", 32'(want.red), 32'(pix_if.red));
                check_field("green", 32'(want.green), 32'(pix_if.green));
                check_field("blue", 32'(want.blue), 32'(pix_if.blue));
                check_field("column_done", 32'(want.done), 32'(pix_if.column_done));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        t_tab_row                      tab [$];
        t_pixel                        px;
        bit                            hit;
        logic [pcpd_pkg::OFFS_W-1:0]   offs [N_PHASES];
        logic [pcpd_pkg::HEIGHT_W-1:0] hts [N_PHASES];

        i_rst_n            <= 1'b0;
        item_if.valid      <= 1'b0;
        item_if.action     <= pcpd_pkg::ACT_LOAD;
        item_if.byte_value <= '0;
        item_if.load_rgb   <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= pcpd_pkg::CFG_Y_OFFSET;
        cfg_data           <= '0;

        ph     = pcpd_pkg::PH_TOP;
        top_q  = '0;
        left_q = '0;
        crow   = '0;
        y_off  = '0;
        tex_h  = pcpd_pkg::TEX_HEIGHT_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: offset 0, height 128
        tab.push_back(tab_load(8'd0, 24'hFFFFFF));
        tab.push_back(tab_load(8'd255, 24'h000000));
        tab.push_back(tab_load(8'd1, 24'h123456));
        tab.push_back(tab_end());
        tab.push_back(tab_byte(8'd0));
        tab.push_back(tab_byte(8'd3));
        tab.push_back(tab_byte(8'd0));
        tab.push_back(tab_pix(8'd0, 15'd0, 24'hFFFFFF));
        tab.push_back(tab_pix(8'd255, 15'd1, 24'h000000));
        tab.push_back(tab_pix(8'd1, 15'd2, 24'h123456));
        tab.push_back(tab_byte(8'hAA));
        tab.push_back(tab_byte(8'd125));
        tab.push_back(tab_byte(8'd5));
        tab.push_back(tab_load(8'd2, 24'hABCDEF));   // load inside a post
        tab.push_back(tab_byte(8'd9));
        tab.push_back(tab_pix(8'd2, 15'd125, 24'hABCDEF));
        tab.push_back(tab_pix(8'd0, 15'd126, 24'hFFFFFF));
        tab.push_back(tab_pix(8'd1, 15'd127, 24'h123456));
        tab.push_back(tab_drop(8'd0));               // row 128 past the bottom
        tab.push_back(tab_drop(8'd255));
        tab.push_back(tab_byte(8'd0));
        tab.push_back(tab_byte(8'd7));               // empty post
        tab.push_back(tab_byte(8'd0));
        tab.push_back(tab_byte(8'd3));
        tab.push_back(tab_byte(8'd4));
        tab.push_back(tab_end());

        foreach (tab[i]) begin
            send_item(tab[i].it, hit, px);
            if (tab[i].typed) begin
                hit = tab[i].has_res;
                px  = tab[i].res;
            end
            if (hit) pending_pix.push_back(px);
        end
        drain();

        offs[0] = 16'sd0;      hts[0] = 15'd128;
        offs[1] = -16'sd32768; hts[1] = 15'd32767;
        offs[2] = 16'sd32767;  hts[2] = 15'd32767;
        offs[3] = 16'sd32500;  hts[3] = 15'd32767;
        offs[4] = -16'sd40;    hts[4] = 15'd90;
        offs[5] = 16'sd0;      hts[5] = 15'd0;
        offs[6] = -16'sd300;   hts[6] = 15'd200;
        offs[7] = 16'sd100;    hts[7] = 15'd1;
        offs[8] = 16'($urandom_range(0, 400) - 200);
        hts[8]  = 15'($urandom_range(1, 400));
        offs[9] = 16'($urandom);
        hts[9]  = 15'($urandom);

        for (int p = 0; p < N_PHASES; p++) begin
            calm = (p % 3 == 2);
            set_config(offs[p], hts[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 50) drain();
                send_item(random_item(), hit, px);
                if (hit) pending_pix.push_back(px);
            end
            drain();
        end

        if (errs == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
